@@ rtl/ffba_pkg.sv @@
package ffba_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int ADDR_BITS_DEF  = 24;
	localparam int POOL_RESET     = 262144;
	localparam int GRAIN_MASK     = 2047;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

@@ rtl/ffba_req_if.sv @@
interface ffba_req_if #(
	parameter int FW = ffba_pkg::ADDR_BITS_DEF + 1
);
	logic          valid;
	logic          ready;
	logic          req_type;
	logic [FW-1:0] request_size;
	logic [FW-1:0] release_address;

	modport source (output valid, req_type, request_size, release_address, input ready);
	modport sink   (input valid, req_type, request_size, release_address, output ready);
endinterface

@@ rtl/ffba_rsp_if.sv @@
interface ffba_rsp_if #(
	parameter int FW = ffba_pkg::ADDR_BITS_DEF + 1
);
	logic          valid;
	logic          ready;
	logic          success;
	logic [FW-1:0] block_address;
	logic [FW-1:0] block_size;

	modport source (output valid, success, block_address, block_size, input ready);
	modport sink   (input valid, success, block_address, block_size, output ready);
endinterface

@@ rtl/first_fit_block_allocator.sv @@
// first fit block allocator, table of MAX_BLOCKS entries in a one-port-read memory
// allocate: scan; on a split shift later entries up and add the remainder; write entry
// free: scan for the address; merge free right then left neighbours; write the entry
// S_FIN waits while a result is held unaccepted on rsp; one request in flight
// async reset: pool_size 262144 (capped at 2^ADDR_BITS), one free block, no result
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [ADDR_BITS:0] cfg_wdata,
	ffba_req_if.sink         req,
	ffba_rsp_if.source       rsp
);

	localparam int FW = ADDR_BITS + 1;
	localparam int AW = FW + 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int EW = 1 + 2 * FW;
	localparam logic [FW-1:0] POOL_LIMIT = {1'b1, {ADDR_BITS{1'b0}}};
	localparam logic [FW-1:0] POOL_RST =
		(longint'(ffba_pkg::POOL_RESET) > (longint'(1) << ADDR_BITS)) ?
		POOL_LIMIT : FW'(ffba_pkg::POOL_RESET);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);
	localparam logic [AW-1:0] GRAIN   = AW'(ffba_pkg::GRAIN_MASK);

	typedef enum logic [13:0] {
		S_IDLE   = 14'h0001,
		S_RD     = 14'h0002,
		S_CHK    = 14'h0004,
		S_SH_RD  = 14'h0008,
		S_SH_WR  = 14'h0010,
		S_SPLIT  = 14'h0020,
		S_RN_RD  = 14'h0040,
		S_RN_CHK = 14'h0080,
		S_RM_RD  = 14'h0100,
		S_RM_WR  = 14'h0200,
		S_LN     = 14'h0400,
		S_LN_CHK = 14'h0800,
		S_WR     = 14'h1000,
		S_FIN    = 14'h2000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] j_q;
	logic          left_q;
	logic          out_valid_q;
	logic [FW-1:0] pool_q;

	logic          type_q;
	logic [AW-1:0] need_q;
	logic [FW-1:0] addr_q;
	logic [FW-1:0] cur_off_q;
	logic [FW-1:0] cur_size_q;
	logic          cur_used_q;
	logic [FW-1:0] rem_q;
	logic          ok_q;
	logic          res_ok_q;
	logic [FW-1:0] res_addr_q;
	logic [FW-1:0] res_size_q;

	logic [CW-1:0] idx_p1;
	logic [CW-1:0] idx_m1;
	logic [CW-1:0] j_p1;
	logic [CW-1:0] j_m1;
	logic [CW-1:0] cnt_m1;

	ffba_pkg::alu_op_t alu_op;
	logic [AW-1:0]     alu_a;
	logic [AW-1:0]     alu_b;
	logic [AW-1:0]     alu_res;
	logic              alu_borrow;
	logic              alu_zero;

	logic [IW-1:0] rd_addr;
	logic [EW-1:0] rd_data;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic          e_used;
	logic [FW-1:0] e_off;
	logic [FW-1:0] e_size;
	logic          fit;
	logic          split;
	logic          match;
	logic          slot_free;

	assign idx_p1 = idx_q + CW'(1);
	assign idx_m1 = idx_q - CW'(1);
	assign j_p1   = j_q + CW'(1);
	assign j_m1   = j_q - CW'(1);
	assign cnt_m1 = count_q - CW'(1);

	assign e_used = rd_data[EW-1];
	assign e_off  = rd_data[2*FW-1:FW];
	assign e_size = rd_data[FW-1:0];

	assign fit       = !e_used && !alu_borrow;
	assign split     = !alu_zero && (count_q < MAX_CNT);
	assign match     = alu_zero;
	assign slot_free = !out_valid_q || rsp.ready;

	ffba_alu #(
		.W (AW)
	) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.res    (alu_res),
		.borrow (alu_borrow),
		.zero   (alu_zero)
	);

	ffba_table #(
		.DEPTH (MAX_BLOCKS),
		.FW    (FW)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.reload    (cfg_we),
		.dflt_size (pool_q),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	always_comb begin
		alu_op  = ffba_pkg::ALU_SUB;
		alu_a   = '0;
		alu_b   = '0;
		rd_addr = idx_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[IW-1:0];
		wr_data = {cur_used_q, cur_off_q, cur_size_q};
		case (state_q)
			S_IDLE: begin
				alu_op = ffba_pkg::ALU_ADD;
				alu_a  = {1'b0, req.request_size};
				alu_b  = GRAIN;
			end
			S_CHK: begin
				if (type_q == ffba_pkg::REQ_FREE) begin
					alu_a = {1'b0, e_off};
					alu_b = {1'b0, addr_q};
				end else begin
					alu_a = {1'b0, e_size};
					alu_b = need_q;
				end
			end
			S_SH_RD: rd_addr = j_m1[IW-1:0];
			S_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IW-1:0];
				wr_data = rd_data;
			end
			S_SPLIT: begin
				alu_op  = ffba_pkg::ALU_ADD;
				alu_a   = {1'b0, cur_off_q};
				alu_b   = need_q;
				wr_en   = 1'b1;
				wr_addr = idx_p1[IW-1:0];
				wr_data = {1'b0, alu_res[FW-1:0], rem_q};
			end
			S_RN_RD: rd_addr = idx_p1[IW-1:0];
			S_RN_CHK: begin
				alu_op = ffba_pkg::ALU_ADD;
				alu_a  = {1'b0, cur_size_q};
				alu_b  = {1'b0, e_size};
			end
			S_RM_RD: rd_addr = j_p1[IW-1:0];
			S_RM_WR: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IW-1:0];
				wr_data = rd_data;
			end
			S_LN: rd_addr = idx_m1[IW-1:0];
			S_LN_CHK: begin
				alu_op = ffba_pkg::ALU_ADD;
				alu_a  = {1'b0, e_size};
				alu_b  = {1'b0, cur_size_q};
			end
			S_WR: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= CW'(1);
			idx_q       <= '0;
			j_q         <= '0;
			left_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pool_q      <= POOL_RST;
		end else begin
			if (cfg_we) begin
				pool_q  <= (cfg_wdata > POOL_LIMIT) ? POOL_LIMIT : cfg_wdata;
				count_q <= CW'(1);
			end
			out_valid_q <= ((state_q == S_FIN) && slot_free) || (out_valid_q && !rsp.ready);
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= (idx_q == count_q) ? S_FIN : S_CHK;
				S_CHK: begin
					if (type_q == ffba_pkg::REQ_FREE) begin
						if (match) begin
							state_q <= (idx_p1 < count_q) ? S_RN_RD : S_LN;
						end else begin
							idx_q   <= idx_p1;
							state_q <= S_RD;
						end
					end else if (fit) begin
						if (split) begin
							j_q     <= count_q;
							state_q <= S_SH_RD;
						end else begin
							state_q <= S_WR;
						end
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_RD;
					end
				end
				S_SH_RD: state_q <= (j_q == idx_p1) ? S_SPLIT : S_SH_WR;
				S_SH_WR: begin
					j_q     <= j_m1;
					state_q <= S_SH_RD;
				end
				S_SPLIT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_WR;
				end
				S_RN_RD: state_q <= S_RN_CHK;
				S_RN_CHK: begin
					if (!e_used) begin
						j_q     <= idx_p1;
						left_q  <= 1'b0;
						state_q <= S_RM_RD;
					end else begin
						state_q <= S_LN;
					end
				end
				S_RM_RD: begin
					if (j_q == cnt_m1) begin
						count_q <= cnt_m1;
						state_q <= left_q ? S_WR : S_LN;
					end else begin
						state_q <= S_RM_WR;
					end
				end
				S_RM_WR: begin
					j_q     <= j_p1;
					state_q <= S_RM_RD;
				end
				S_LN: state_q <= (idx_q == '0) ? S_WR : S_LN_CHK;
				S_LN_CHK: begin
					if (!e_used) begin
						j_q     <= idx_q;
						idx_q   <= idx_m1;
						left_q  <= 1'b1;
						state_q <= S_RM_RD;
					end else begin
						state_q <= S_WR;
					end
				end
				S_WR: state_q <= S_FIN;
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					type_q <= req.req_type;
					need_q <= alu_res & ~GRAIN;
					addr_q <= req.release_address;
					ok_q   <= 1'b0;
				end
			end
			S_CHK: begin
				cur_off_q  <= e_off;
				cur_size_q <= e_size;
				cur_used_q <= e_used;
				if (type_q == ffba_pkg::REQ_FREE) begin
					if (match) begin
						ok_q       <= 1'b1;
						cur_used_q <= 1'b0;
					end
				end else if (fit) begin
					ok_q       <= 1'b1;
					cur_used_q <= 1'b1;
					if (split) begin
						cur_size_q <= need_q[FW-1:0];
						rem_q      <= alu_res[FW-1:0];
					end
				end
			end
			S_RN_CHK: begin
				if (!e_used) begin
					cur_size_q <= alu_res[FW-1:0];
				end
			end
			S_LN_CHK: begin
				if (!e_used) begin
					cur_size_q <= alu_res[FW-1:0];
					cur_off_q  <= e_off;
					cur_used_q <= e_used;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					res_ok_q <= ok_q;
					if (ok_q && type_q == ffba_pkg::REQ_ALLOC) begin
						res_addr_q <= cur_off_q;
						res_size_q <= cur_size_q;
					end else begin
						res_addr_q <= '0;
						res_size_q <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.success       = res_ok_q;
	assign rsp.block_address = res_addr_q;
	assign rsp.block_size    = res_size_q;

endmodule

@@ rtl/ffba_alu.sv @@
module ffba_alu #(
	parameter int W = ffba_pkg::ADDR_BITS_DEF + 2
) (
	input  ffba_pkg::alu_op_t op,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	output logic [W-1:0]      res,
	output logic              borrow,
	output logic              zero
);

	logic [W:0] sum;

	always_comb begin
		case (op)
			ffba_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
			ffba_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
			default:           sum = '0;
		endcase
	end

	assign res    = sum[W-1:0];
	assign borrow = sum[W];
	assign zero   = (sum == '0);

endmodule

@@ rtl/ffba_table.sv @@
module ffba_table #(
	parameter int DEPTH = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int FW    = ffba_pkg::ADDR_BITS_DEF + 1,
	localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int EW   = 1 + 2 * FW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          reload,
	input  logic [FW-1:0] dflt_size,
	input  logic [IW-1:0] rd_addr,
	output logic [EW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  logic [EW-1:0] wr_data
);

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;
	logic          e0_written_q;
	logic          sel_dflt_q;

	// entry 0 reads as the reload value until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_written_q <= 1'b0;
			sel_dflt_q   <= 1'b0;
		end else begin
			sel_dflt_q <= (rd_addr == '0) && !e0_written_q;
			if (reload) begin
				e0_written_q <= 1'b0;
			end else if (wr_en && wr_addr == '0) begin
				e0_written_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = sel_dflt_q ? {1'b0, {FW{1'b0}}, dflt_size} : rd_q;

endmodule
